FILE: rtl/tts_pkg.sv
package tts_pkg;

    localparam int TABLE_SIZE       = 33;
    localparam int MAX_CHANNELS_DEF = 20;
    localparam int TABLE_POINTS_DEF = 33;

    localparam int MV_W   = 12;
    localparam int T_W    = 12;
    localparam int TH_W   = T_W + 1;
    localparam int SUM_W  = 17;
    localparam int CNT_W  = 6;
    localparam int AW     = $clog2(TABLE_SIZE);
    // widest segment span (70 mV) and largest count both fit in seven bits
    localparam int DVSR_W = 7;
    localparam int DIV_W  = 17;
    localparam int DCNT_W = $clog2(DIV_W + 1);

    localparam logic signed [T_W-1:0] TEMP_BASE16 = -12'sd640;
    localparam logic signed [T_W-1:0] TEMP_TOP16  = 12'sd1920;

    // divider voltage in mV at -40 C, -35 C, ... 120 C
    localparam logic [MV_W-1:0] TBL_MV [TABLE_SIZE] = '{
        12'd2440, 12'd2420, 12'd2400, 12'd2380, 12'd2350, 12'd2320, 12'd2270,
        12'd2230, 12'd2170, 12'd2110, 12'd2050, 12'd1990, 12'd1920, 12'd1860,
        12'd1800, 12'd1740, 12'd1680, 12'd1630, 12'd1590, 12'd1550, 12'd1510,
        12'd1480, 12'd1450, 12'd1430, 12'd1400, 12'd1380, 12'd1370, 12'd1350,
        12'd1340, 12'd1330, 12'd1320, 12'd1310, 12'd1300
    };

    typedef struct packed {
        logic load;
        logic search_step;
        logic div_start_t;
        logic finish_t;
        logic div_start_a;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic temp_ok;
        logic seg_found;
        logic div_done;
        logic last;
        logic cnt_zero;
        logic out_free;
    } t_status;

endpackage

FILE: rtl/tts_div.sv
module tts_div
    import tts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_W-1:0]  i_dividend,
    input  logic [DVSR_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DIV_W-1:0]  o_quotient,
    output logic [DVSR_W-1:0] o_remainder
);

    logic [DCNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_quo;
    logic [DVSR_W-1:0] r_rem;
    logic [DVSR_W-1:0] r_dvsr;

    logic [DVSR_W:0] w_shift;
    logic [DVSR_W:0] w_sub;
    logic            w_ge;

    // restoring division, one quotient bit per cycle
    assign w_shift = {r_rem, r_quo[DIV_W-1]};
    assign w_sub   = w_shift - {1'b0, r_dvsr};
    assign w_ge    = w_shift >= {1'b0, r_dvsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DCNT_W'(DIV_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - DCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_dvsr <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
            r_rem <= w_ge ? w_sub[DVSR_W-1:0] : w_shift[DVSR_W-1:0];
        end
    end

    assign o_done      = (r_cnt == '0);
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

FILE: rtl/tts_dpath.sv
module tts_dpath
    import tts_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int TABLE_POINTS = TABLE_POINTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic [MV_W-1:0]       i_sample_mv,
    input  logic                  i_last_in_set,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic signed [T_W-1:0] o_temp_sixteenths,
    output logic                  o_temp_valid,
    output logic                  o_set_done,
    output logic                  o_none_valid,
    output logic [CNT_W-1:0]      o_valid_count,
    output logic signed [T_W-1:0] o_lowest_sixteenths,
    output logic signed [T_W-1:0] o_highest_sixteenths,
    output logic signed [T_W-1:0] o_average_sixteenths
);

    localparam int POINTS = (TABLE_POINTS > TABLE_SIZE) ? TABLE_SIZE : TABLE_POINTS;
    localparam bit POINTS_OK = (POINTS >= 2);
    localparam logic [MV_W-1:0] MV_HIGH = TBL_MV[0];
    localparam logic [MV_W-1:0] MV_LOW  = TBL_MV[(POINTS >= 2) ? POINTS - 1 : 0];

    logic [MV_W-1:0]         r_mv;
    logic                    r_last;
    logic                    r_temp_ok;
    logic [AW-1:0]           r_idx;
    logic signed [T_W-1:0]   r_temp;
    logic signed [T_W-1:0]   r_min;
    logic signed [T_W-1:0]   r_max;
    logic signed [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_out_valid;

    logic [MV_W-1:0]         w_vh;
    logic [MV_W-1:0]         w_vl;
    logic [MV_W-1:0]         w_d;
    logic [MV_W-1:0]         w_diff;
    logic [DIV_W-1:0]        w_x;
    logic signed [TH_W-1:0]  w_th;
    logic signed [TH_W-1:0]  w_sumq;
    logic signed [TH_W-1:0]  w_t;
    logic signed [T_W-1:0]   w_t12;
    logic [DIV_W-1:0]        w_sum_abs;
    logic                    w_div_start;
    logic [DIV_W-1:0]        w_dividend;
    logic [DVSR_W-1:0]       w_divisor;
    logic                    w_div_done;
    logic [DIV_W-1:0]        w_quo;
    logic [DVSR_W-1:0]       w_rem;
    logic [T_W-1:0]          w_q12;
    logic signed [T_W-1:0]   w_avg;
    logic                    w_in_range;
    logic                    w_room;
    logic                    w_out_free;

    assign w_vh   = TBL_MV[r_idx];
    assign w_vl   = TBL_MV[r_idx + AW'(1)];
    assign w_d    = w_vh - w_vl;
    assign w_diff = w_vh - r_mv;
    // times 80 as two shifts
    assign w_x    = DIV_W'({w_diff, 6'b0}) + DIV_W'({w_diff, 4'b0});
    assign w_th   = TH_W'(TEMP_BASE16) + $signed(TH_W'({r_idx, 6'b0}))
                  + $signed(TH_W'({r_idx, 4'b0}));

    // th + q, bumped by one where that sum is negative and the division inexact
    assign w_sumq = w_th + $signed(TH_W'(w_quo));
    assign w_t    = w_sumq + ((w_sumq < 0 && w_rem != '0) ? TH_W'(1) : TH_W'(0));
    assign w_t12  = w_t[T_W-1:0];

    assign w_sum_abs   = r_sum[SUM_W-1] ? DIV_W'(-r_sum) : DIV_W'(r_sum);
    assign w_div_start = i_cmd.div_start_t | i_cmd.div_start_a;
    assign w_dividend  = i_cmd.div_start_a ? w_sum_abs : w_x;
    assign w_divisor   = i_cmd.div_start_a ? DVSR_W'(r_cnt) : w_d[DVSR_W-1:0];

    assign w_q12 = w_quo[T_W-1:0];
    assign w_avg = r_sum[SUM_W-1] ? -$signed(w_q12) : $signed(w_q12);

    assign w_in_range = POINTS_OK && (i_sample_mv <= MV_HIGH) && (i_sample_mv >= MV_LOW);
    assign w_room     = r_cnt < CNT_W'(MAX_CHANNELS);
    assign w_out_free = !r_out_valid || !i_out_stall;

    tts_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mv      <= i_sample_mv;
            r_last    <= i_last_in_set;
            r_temp_ok <= w_in_range;
            r_idx     <= '0;
            r_temp    <= '0;
        end else if (i_cmd.search_step) begin
            r_idx <= r_idx + AW'(1);
        end else if (i_cmd.finish_t) begin
            r_temp <= w_t12;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= TEMP_TOP16;
            r_max <= TEMP_BASE16;
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_cmd.emit && r_last) begin
            r_min <= TEMP_TOP16;
            r_max <= TEMP_BASE16;
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_cmd.finish_t && w_room) begin
            if (w_t12 < r_min) begin
                r_min <= w_t12;
            end
            if (w_t12 > r_max) begin
                r_max <= w_t12;
            end
            r_sum <= r_sum + SUM_W'(w_t12);
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_temp_sixteenths    <= r_temp;
            o_temp_valid         <= r_temp_ok;
            o_set_done           <= r_last;
            o_none_valid         <= r_last && (r_cnt == '0);
            o_valid_count        <= r_last ? r_cnt : '0;
            o_lowest_sixteenths  <= (r_last && r_cnt != '0) ? r_min : '0;
            o_highest_sixteenths <= (r_last && r_cnt != '0) ? r_max : '0;
            o_average_sixteenths <= (r_last && r_cnt != '0) ? w_avg : '0;
        end
    end

    assign o_out_valid = r_out_valid;

    assign o_status.temp_ok   = r_temp_ok;
    assign o_status.seg_found = r_mv >= w_vl;
    assign o_status.div_done  = w_div_done;
    assign o_status.last      = r_last;
    assign o_status.cnt_zero  = (r_cnt == '0);
    assign o_status.out_free  = w_out_free;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_CHANNELS))
        else $error("valid count beyond channel limit");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (r_min <= r_max))
        else $error("running minimum above running maximum");

    a_set_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_last) |=> (r_cnt == '0 && r_sum == '0))
        else $error("statistics not cleared after last beat of set");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> w_out_free)
        else $error("result loaded over an unaccepted beat");

endmodule

FILE: rtl/tts_ctrl.sv
module tts_ctrl
    import tts_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_DIV_T  = 3'd2;
    localparam logic [2:0] ST_STATS  = 3'd3;
    localparam logic [2:0] ST_DIV_A  = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (!i_status.temp_ok) begin
                    n_state = ST_STATS;
                end else if (i_status.seg_found) begin
                    o_cmd.div_start_t = 1'b1;
                    n_state           = ST_DIV_T;
                end else begin
                    o_cmd.search_step = 1'b1;
                end
            end
            ST_DIV_T: begin
                if (i_status.div_done) begin
                    o_cmd.finish_t = 1'b1;
                    n_state        = ST_STATS;
                end
            end
            ST_STATS: begin
                if (i_status.last && !i_status.cnt_zero) begin
                    o_cmd.div_start_a = 1'b1;
                    n_state           = ST_DIV_A;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_DIV_A: begin
                if (i_status.div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

FILE: rtl/thermistor_table_temp_statistics_unit.sv
// channel  direction  handshake                 payload
// in       input      i_in_valid / o_in_stall   i_sample_mv, i_last_in_set
// out      output     o_out_valid / i_out_stall o_temp_sixteenths ... o_average_sixteenths
//
// one beat in flight: an out-of-range voltage skips the search and divide; an
// in-range one does a table segment search, one point per cycle, then a divide
// a set's last beat, if any beat counted, adds an average divide on the same divider
// synchronous active-low reset clears the controller, output valid and statistics
// a finished result waits in the output register; the next input beat is taken
// meanwhile, and the controller holds before loading the following result
module thermistor_table_temp_statistics_unit
    import tts_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int TABLE_POINTS = TABLE_POINTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [MV_W-1:0]       i_sample_mv,
    input  logic                  i_last_in_set,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [T_W-1:0] o_temp_sixteenths,
    output logic                  o_temp_valid,
    output logic                  o_set_done,
    output logic                  o_none_valid,
    output logic [CNT_W-1:0]      o_valid_count,
    output logic signed [T_W-1:0] o_lowest_sixteenths,
    output logic signed [T_W-1:0] o_highest_sixteenths,
    output logic signed [T_W-1:0] o_average_sixteenths
);

    t_cmd    w_cmd;
    t_status w_status;

    tts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tts_dpath #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .TABLE_POINTS (TABLE_POINTS)
    ) u_dpath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .o_status             (w_status),
        .i_sample_mv          (i_sample_mv),
        .i_last_in_set        (i_last_in_set),
        .i_out_stall          (i_out_stall),
        .o_out_valid          (o_out_valid),
        .o_temp_sixteenths    (o_temp_sixteenths),
        .o_temp_valid         (o_temp_valid),
        .o_set_done           (o_set_done),
        .o_none_valid         (o_none_valid),
        .o_valid_count        (o_valid_count),
        .o_lowest_sixteenths  (o_lowest_sixteenths),
        .o_highest_sixteenths (o_highest_sixteenths),
        .o_average_sixteenths (o_average_sixteenths)
    );

endmodule
